FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion on the house clock and reset names.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

FILE: hdl/rtsq_pkg.sv
// Shared types, constants and helpers of the touch sample qualifier.
// No dependencies; every other file but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package rtsq_pkg;

  // Conversion width and the derived arithmetic widths
  localparam int SAMPLE_BITS = 12;
  localparam int PROD_W      = 3 * SAMPLE_BITS;
  localparam int Z_W         = PROD_W + 1 - SAMPLE_BITS;
  localparam int DIV_CNT_W   = $clog2(PROD_W);
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 2 * SAMPLE_BITS;
  localparam int FLIP_W      = 2;
  localparam int TICK_W      = 16;

  // Rounding bias added to the quotient before the final shift
  localparam logic [SAMPLE_BITS-1:0] ROUND_BIAS =
    SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Window layout: maximum in the upper half, minimum in the lower half
  typedef struct packed {
    sample_t hi;
    sample_t lo;
  } window_t;

  typedef struct packed {
    sample_t           plate;
    window_t           press_win;
    window_t           x_win;
    window_t           y_win;
    logic [FLIP_W-1:0] flip;
    logic [TICK_W-1:0] penup;
  } rtsq_cfg_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PLATE     = 3'd0,
    CFG_PRESS_WIN = 3'd1,
    CFG_X_WIN     = 3'd2,
    CFG_Y_WIN     = 3'd3,
    CFG_FLIP      = 3'd4,
    CFG_PENUP     = 3'd5
  } cfg_idx_e;

  localparam sample_t           PLATE_RESET = SAMPLE_BITS'(450);
  localparam window_t           FULL_WINDOW = '{hi: '1, lo: '0};
  localparam logic [TICK_W-1:0] PENUP_RESET = TICK_W'(30);

  typedef struct packed {
    logic    ok;
    sample_t val;
  } axis_t;

  // Mirror an axis within its window if asked, then test the window
  function automatic axis_t place_axis(sample_t v, window_t w, logic flip);
    logic signed [SAMPLE_BITS+1:0] lo_s;
    logic signed [SAMPLE_BITS+1:0] hi_s;
    logic signed [SAMPLE_BITS+1:0] v_s;
    logic signed [SAMPLE_BITS+1:0] t;
    axis_t                         r;
    lo_s  = $signed({2'b00, w.lo});
    hi_s  = $signed({2'b00, w.hi});
    v_s   = $signed({2'b00, v});
    t     = flip ? (hi_s + lo_s - v_s) : v_s;
    r.ok  = (t >= lo_s) && (t <= hi_s);
    r.val = t[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/rtsq_cfg.sv
// Configuration register file of the touch sample qualifier.
// Depends on rtsq_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module rtsq_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rtsq_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [rtsq_pkg::CFG_DW-1:0] cfg_wdata_i,
  output rtsq_pkg::rtsq_cfg_t        cfg_o
);
  import rtsq_pkg::*;

  rtsq_cfg_t cfg_q;

  // Write one register per enabled cycle; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plate     <= PLATE_RESET;
      cfg_q.press_win <= FULL_WINDOW;
      cfg_q.x_win     <= FULL_WINDOW;
      cfg_q.y_win     <= FULL_WINDOW;
      cfg_q.flip      <= '0;
      cfg_q.penup     <= PENUP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PLATE:     cfg_q.plate     <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_PRESS_WIN: cfg_q.press_win <= cfg_wdata_i;
        CFG_X_WIN:     cfg_q.x_win     <= cfg_wdata_i;
        CFG_Y_WIN:     cfg_q.y_win     <= cfg_wdata_i;
        CFG_FLIP:      cfg_q.flip      <= cfg_wdata_i[FLIP_W-1:0];
        CFG_PENUP:     cfg_q.penup     <= cfg_wdata_i[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/rtsq_div.sv
// Restoring divider, one quotient bit per cycle, for the pressure quotient.
// Depends on rtsq_pkg for the operand widths.
`timescale 1ns / 1ps

module rtsq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rtsq_pkg::PROD_W-1:0] dividend_i,
  input  rtsq_pkg::sample_t           divisor_i,
  output logic                        done_o,
  output logic [rtsq_pkg::PROD_W-1:0] quotient_o
);
  import rtsq_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]    quo_q;
  sample_t              rem_q;
  sample_t              divisor_q;

  logic [SAMPLE_BITS:0] shifted;
  logic [SAMPLE_BITS:0] diff;
  logic                 fits;
  logic                 last_step;

  // One trial subtraction of the shifted remainder
  always_comb begin
    shifted   = {rem_q, quo_q[PROD_W-1]};
    diff      = shifted - {1'b0, divisor_q};
    fits      = shifted >= {1'b0, divisor_q};
    last_step = cnt_q == DIV_CNT_W'(PROD_W - 1);
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift quotient bits in from the right as dividend bits leave the left
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_W-2:0], fits};
      rem_q <= fits ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
    end
  end

  assign done_o     = busy_q && last_step;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/resistive_touch_sample_qualifier_unit.sv
// Touch sample qualifier: top level with sequencer, shared multiplier and output stage.
// Depends on rtsq_pkg, rtsq_cfg and rtsq_div.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) takes one item: a touch sample
//   (opcode 0: X, Y, Z1, Z2 conversions and the pen pin) or a tick (opcode 1).
// - Output channel (out_valid_o / out_stall_i) gives touch reports and
//   releases; last_o marks the final result of an item. A sample gives at
//   most two results, a tick at most one.
// - Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while no item is in flight.
// - A sample that needs a pressure runs two passes through one 24x12
//   multiplier and a 36-step serial divider, one quotient bit per cycle;
//   in_stall_o stays high through MUL1, MUL2, DIV and DECIDE, and in EMIT
//   until its last result is loaded into the output register.
// - A tick, or a sample that needs no pressure, loads its result from ST_EMIT
//   into the output register; with no result the block is ready the next cycle.
// - A stalled receiver holds the output register; the sequencer waits on it
//   before loading a further result, then returns to accept the next item.
// - Reset clears the countdown, drops pending results and restores the
//   registers to their defaults.
`timescale 1ns / 1ps

module resistive_touch_sample_qualifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  rtsq_pkg::sample_t           x_raw_i,
  input  rtsq_pkg::sample_t           y_raw_i,
  input  rtsq_pkg::sample_t           z1_raw_i,
  input  rtsq_pkg::sample_t           z2_raw_i,
  input  logic                        pen_lifted_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rtsq_pkg::sample_t           pos_x_o,
  output rtsq_pkg::sample_t           pos_y_o,
  output rtsq_pkg::sample_t           pressure_o,
  output logic                        touching_o,
  output logic                        last_o,
  // Configuration port
  input  logic                        cfg_we_i,
  input  logic [rtsq_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [rtsq_pkg::CFG_DW-1:0] cfg_wdata_i
);
  import rtsq_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_MUL1   = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL2   = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV    = 3'd3;
  localparam logic [ST_W-1:0] ST_DECIDE = 3'd4;
  localparam logic [ST_W-1:0] ST_EMIT   = 3'd5;

  rtsq_cfg_t cfg;

  logic [ST_W-1:0]   state_q, state_d;
  logic              armed_q, armed_d;
  logic [TICK_W-1:0] count_q, count_d;
  logic              rep_pend_q, rep_pend_d;
  logic              rel_pend_q, rel_pend_d;

  sample_t           x_q, y_q, z1_q, diff_q;
  logic              pen_q;
  logic [PROD_W-1:0] prod_q;
  sample_t           rep_x_q, rep_y_q, rep_p_q;

  logic              out_valid_q, out_valid_d;
  sample_t           out_x_q, out_y_q, out_p_q;
  logic              out_touch_q, out_last_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  logic                   out_load_rep;
  logic                   sample_ok;
  logic [2*SAMPLE_BITS-1:0] mul_a;
  sample_t                mul_b;
  logic [PROD_W-1:0]      mul_y;
  logic                   div_start;
  logic                   div_done;
  logic [PROD_W-1:0]      quotient;
  logic [PROD_W:0]        rounded;
  logic [Z_W-1:0]         press_z;
  logic                   in_range;
  axis_t                  ax, ay;

  rtsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Shared multiplier: (z2 - z1) * x first, then times the plate resistance
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = {SAMPLE_BITS'(0), diff_q};
      mul_b = x_q;
    end else begin
      mul_a = prod_q[2*SAMPLE_BITS-1:0];
      mul_b = cfg.plate;
    end
    mul_y = {SAMPLE_BITS'(0), mul_a} * {(2*SAMPLE_BITS)'(0), mul_b};
  end

  assign div_start = state_q == ST_MUL2;

  rtsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_y),
    .divisor_i  (z1_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Round, shift and test the pressure; place both axes
  always_comb begin
    rounded  = {1'b0, quotient} + (PROD_W+1)'(ROUND_BIAS);
    press_z  = rounded[PROD_W:SAMPLE_BITS];
    in_range = (press_z >= Z_W'(cfg.press_win.lo)) &&
               (press_z <= Z_W'(cfg.press_win.hi));
    ax       = place_axis(x_q, cfg.x_win, cfg.flip[0]);
    ay       = place_axis(y_q, cfg.y_win, cfg.flip[1]);
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sample_ok  = (x_raw_i != '0) && (z1_raw_i != '0);

  // Sequencer and countdown
  always_comb begin
    state_d      = state_q;
    armed_d      = armed_q;
    count_d      = count_q;
    rep_pend_d   = rep_pend_q;
    rel_pend_d   = rel_pend_q;
    out_load     = 1'b0;
    out_load_rep = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i) begin
            if (armed_q) begin
              if (count_q <= TICK_W'(1)) begin
                armed_d    = 1'b0;
                count_d    = '0;
                rel_pend_d = 1'b1;
                state_d    = ST_EMIT;
              end else begin
                count_d = count_q - TICK_W'(1);
              end
            end
          end else if (sample_ok && (z2_raw_i >= z1_raw_i)) begin
            state_d = ST_MUL1;
          end else begin
            // Z2 below Z1 counts as out-of-range pressure
            if (sample_ok) begin
              armed_d = 1'b1;
              count_d = cfg.penup;
            end
            if (pen_lifted_i) begin
              armed_d    = 1'b0;
              count_d    = '0;
              rel_pend_d = 1'b1;
              state_d    = ST_EMIT;
            end
          end
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!in_range) begin
          armed_d = 1'b1;
          count_d = cfg.penup;
        end else begin
          armed_d    = 1'b0;
          count_d    = '0;
          rep_pend_d = ax.ok && ay.ok;
        end
        if (pen_q) begin
          armed_d    = 1'b0;
          count_d    = '0;
          rel_pend_d = 1'b1;
        end
        state_d = (pen_q || (in_range && ax.ok && ay.ok)) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rep_pend_q) begin
            out_load_rep = 1'b1;
            rep_pend_d   = 1'b0;
            if (!rel_pend_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            rel_pend_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      count_q     <= '0;
      rep_pend_q  <= 1'b0;
      rel_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      count_q     <= count_d;
      rep_pend_q  <= rep_pend_d;
      rel_pend_q  <= rel_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item, the products and the report fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= x_raw_i;
      y_q    <= y_raw_i;
      z1_q   <= z1_raw_i;
      diff_q <= z2_raw_i - z1_raw_i;
      pen_q  <= pen_lifted_i;
    end
    if (state_q == ST_MUL1) begin
      prod_q <= mul_y;
    end
    if (state_q == ST_DECIDE) begin
      rep_x_q <= ax.val;
      rep_y_q <= ay.val;
      rep_p_q <= press_z[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      out_x_q     <= out_load_rep ? rep_x_q : '0;
      out_y_q     <= out_load_rep ? rep_y_q : '0;
      out_p_q     <= out_load_rep ? rep_p_q : '0;
      out_touch_q <= out_load_rep;
      out_last_q  <= !(out_load_rep && rel_pend_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pressure_o  = out_p_q;
  assign touching_o  = out_touch_q;
  assign last_o      = out_last_q;

endmodule

FILE: hdl/rtsq_checker.sv
// Port-level checker for the touch sample qualifier, bound to the top level.
// Depends on rtsq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtsq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        opcode_i,
  input rtsq_pkg::sample_t           x_raw_i,
  input rtsq_pkg::sample_t           z1_raw_i,
  input rtsq_pkg::sample_t           z2_raw_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input rtsq_pkg::sample_t           pos_x_o,
  input rtsq_pkg::sample_t           pos_y_o,
  input rtsq_pkg::sample_t           pressure_o,
  input logic                        touching_o,
  input logic                        last_o
);
  import rtsq_pkg::*;

  logic press_acc;
  logic rel_zero;

  // Accepted sample that needs a pressure; all-zero result payload
  assign press_acc = in_valid_i && !in_stall_o && !opcode_i && (x_raw_i != '0) &&
                     (z1_raw_i != '0) && (z2_raw_i >= z1_raw_i);
  assign rel_zero  = (pos_x_o == '0) && (pos_y_o == '0) && (pressure_o == '0);

  // A stalled result stays valid and holds its pressure
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pressure_o))

  // A release carries zero position and pressure
  `ASSERT_STD(a_release_zero, out_valid_o && !touching_o |-> rel_zero)

  // A release is always the final result of its item
  `ASSERT_STD(a_release_last, out_valid_o && !touching_o |-> last_o)

  // A sample that needs a pressure keeps the block busy
  `ASSERT_STD(a_press_busy, press_acc |=> in_stall_o)

endmodule

bind resistive_touch_sample_qualifier_unit rtsq_checker u_rtsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .x_raw_i     (x_raw_i),
  .z1_raw_i    (z1_raw_i),
  .z2_raw_i    (z2_raw_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .pressure_o  (pressure_o),
  .touching_o  (touching_o),
  .last_o      (last_o)
);

FILE: tb/tb.sv
// Regression bench for the resistive touch sample qualifier: directed and random items,
// with results checked against a predictor of pressure, windows and pen-up countdown.
// Depends on rtsq_pkg and resistive_touch_sample_qualifier_unit.
`timescale 1ns / 1ps

module tb;
  import rtsq_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [FLIP_W-1:0] FLIP_X = 2'b01;
  localparam logic [FLIP_W-1:0] FLIP_Y = 2'b10;

  // Register indexes the block does not decode
  localparam logic [CFG_IW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_B = 3'd7;

  localparam sample_t SAMPLE_MAX   = '1;
  localparam int      PRESS_ROUND  = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int      MAX_SHOWN    = 10;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    logic    opcode;
    sample_t x;
    sample_t y;
    sample_t z1;
    sample_t z2;
    logic    pen_lifted;
  } touch_item_t;

  typedef struct packed {
    sample_t pos_x;
    sample_t pos_y;
    sample_t pressure;
    logic    touching;
    logic    last;
  } touch_report_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_style_e;

  // Predicts the touch reports and releases of each item and holds them until they arrive
  class touch_report_tracker;
    sample_t           plate;
    window_t           press_win;
    window_t           x_win;
    window_t           y_win;
    logic [FLIP_W-1:0] flip;
    logic [TICK_W-1:0] penup;
    bit                armed;
    logic [TICK_W-1:0] countdown;
    touch_report_t     expected_reports[$];
    int unsigned       mismatches;
    int unsigned       failures;

    function new();
      plate      = PLATE_RESET;
      press_win  = FULL_WINDOW;
      x_win      = FULL_WINDOW;
      y_win      = FULL_WINDOW;
      flip       = '0;
      penup      = PENUP_RESET;
      armed      = 1'b0;
      countdown  = '0;
      mismatches = 0;
      failures   = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_PLATE:     plate = data[SAMPLE_BITS-1:0];
        CFG_PRESS_WIN: press_win = window_t'(data);
        CFG_X_WIN:     x_win = window_t'(data);
        CFG_Y_WIN:     y_win = window_t'(data);
        CFG_FLIP:      flip = data[FLIP_W-1:0];
        CFG_PENUP:     penup = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction

    // Mirror within the window if asked; reject anything outside it, negatives too
    function bit fit_axis(sample_t v, window_t w, bit mirror, output sample_t placed);
      int lo;
      int hi;
      int t;
      lo = w.lo;
      hi = w.hi;
      t  = v;
      if (mirror) t = hi + lo - t;
      if (t < lo || t > hi) return 1'b0;
      placed = t[SAMPLE_BITS-1:0];
      return 1'b1;
    endfunction

    function void add_report(sample_t px, sample_t py, sample_t pr, logic touching);
      touch_report_t r;
      r.pos_x    = px;
      r.pos_y    = py;
      r.pressure = pr;
      r.touching = touching;
      r.last     = 1'b0;
      expected_reports.push_back(r);
    endfunction

    function void predict(touch_item_t it);
      logic [63:0] prod;
      logic [63:0] press;
      sample_t     px;
      sample_t     py;
      bit          in_range;
      int unsigned n_before;
      n_before = expected_reports.size();
      if (it.opcode == OP_TICK) begin
        // Advance an armed countdown; release when it runs out
        if (armed) begin
          if (countdown <= 1) begin
            armed     = 1'b0;
            countdown = '0;
            add_report('0, '0, '0, 1'b0);
          end else begin
            countdown = countdown - 1'b1;
          end
        end
      end else begin
        if (it.x != '0 && it.z1 != '0) begin
          in_range = 1'b0;
          press    = '0;
          if (it.z2 >= it.z1) begin
            prod     = 64'(it.z2 - it.z1) * 64'(it.x) * 64'(plate);
            press    = (prod / 64'(it.z1) + 64'(PRESS_ROUND)) >> SAMPLE_BITS;
            in_range = press >= 64'(press_win.lo) && press <= 64'(press_win.hi);
          end
          if (!in_range) begin
            armed     = 1'b1;
            countdown = penup;
          end else begin
            armed     = 1'b0;
            countdown = '0;
            if (fit_axis(it.x, x_win, (flip & FLIP_X) != 0, px) &&
                fit_axis(it.y, y_win, (flip & FLIP_Y) != 0, py))
              add_report(px, py, press[SAMPLE_BITS-1:0], 1'b1);
          end
        end
        // Lifted pen: release right away
        if (it.pen_lifted) begin
          armed     = 1'b0;
          countdown = '0;
          add_report('0, '0, '0, 1'b0);
        end
      end
      if (expected_reports.size() > n_before)
        expected_reports[expected_reports.size() - 1].last = 1'b1;
    endfunction

    function void note_mismatch(string why, touch_report_t want, touch_report_t got);
      mismatches++;
      failures++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t %s: expected x=%0d y=%0d p=%0d touch=%0b last=%0b,",
                 $time, why, want.pos_x, want.pos_y, want.pressure, want.touching,
                 want.last,
                 "got x=%0d y=%0d p=%0d touch=%0b last=%0b",
                 got.pos_x, got.pos_y, got.pressure, got.touching, got.last);
    endfunction

    function void check_report(sample_t px, sample_t py, sample_t pr, logic touching,
                               logic last_flag);
      touch_report_t got;
      touch_report_t want;
      got.pos_x    = px;
      got.pos_y    = py;
      got.pressure = pr;
      got.touching = touching;
      got.last     = last_flag;
      if (expected_reports.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
        return;
      end
      want = expected_reports.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.pressure !== want.pressure || got.touching !== want.touching ||
          got.last !== want.last)
        note_mismatch("result mismatch", want, got);
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              opcode_i     = OP_SAMPLE;
  sample_t           x_raw_i      = '0;
  sample_t           y_raw_i      = '0;
  sample_t           z1_raw_i     = '0;
  sample_t           z2_raw_i     = '0;
  logic              pen_lifted_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  sample_t           pos_x_o;
  sample_t           pos_y_o;
  sample_t           pressure_o;
  logic              touching_o;
  logic              last_o;
  logic              cfg_we_i     = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i  = '0;
  logic [CFG_DW-1:0] cfg_wdata_i  = '0;

  touch_report_tracker reports;
  int unsigned         idle_cycles = 0;
  int unsigned         burst_left  = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_run   = 0;
  stall_style_e        stall_style = STALL_NONE;

  resistive_touch_sample_qualifier_unit DUT (.*);

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Stall the result channel in a randomly re-picked style: none, light, heavy or bursts
  always @(negedge clk_i) begin
    if (cycle_count % 128 == 0) stall_style = stall_style_e'($urandom_range(0, 3));
    cycle_count++;
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 24);
        end
      end
    endcase
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      reports.check_report(pos_x_o, pos_y_o, pressure_o, touching_o, last_o);
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("resistive_touch_sample_qualifier_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [CFG_DW-1:0] pack_window(int lo, int hi);
    return {sample_t'(hi), sample_t'(lo)};
  endfunction

  function automatic touch_item_t make_tick();
    touch_item_t it;
    it.opcode     = OP_TICK;
    it.x          = sample_t'($urandom);
    it.y          = sample_t'($urandom);
    it.z1         = sample_t'($urandom);
    it.z2         = sample_t'($urandom);
    it.pen_lifted = 1'($urandom);
    return it;
  endfunction

  function automatic touch_item_t make_sample(int x, int y, int z1, int z2, bit pen);
    touch_item_t it;
    it.opcode     = OP_SAMPLE;
    it.x          = sample_t'(x);
    it.y          = sample_t'(y);
    it.z1         = sample_t'(z1);
    it.z2         = sample_t'(z2);
    it.pen_lifted = pen;
    return it;
  endfunction

  function automatic sample_t axis_in(window_t w);
    if (w.lo <= w.hi && $urandom_range(0, 7) != 0)
      return sample_t'($urandom_range(w.lo, w.hi));
    return sample_t'($urandom_range(0, 4095));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_window();
    int unsigned a;
    int unsigned b;
    a = $urandom_range(0, 4095);
    b = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return pack_window(0, 4095);
      4, 5, 6:    return (a <= b) ? pack_window(a, b) : pack_window(b, a);
      7:          return pack_window(a, a);
      8:          return (a <= b) ? pack_window(b, a) : pack_window(a, b);
      default:    return CFG_DW'($urandom);
    endcase
  endfunction

  // Mostly plausible touches aimed into the pressure window; the rest ticks and noise
  function automatic touch_item_t random_item();
    touch_item_t     it;
    int unsigned     pick;
    longint unsigned span;
    longint unsigned target;
    longint unsigned z2_sum;
    window_t         pw;
    pick = $urandom_range(0, 99);
    it   = make_tick();
    if (pick < 30) return it;
    it.opcode = OP_SAMPLE;
    if (pick < 42) return it;
    it.pen_lifted = ($urandom_range(0, 11) == 0);
    if (pick < 47) begin
      if ($urandom_range(0, 1)) it.x = '0;
      else it.z1 = '0;
      return it;
    end
    it.x  = axis_in(reports.x_win);
    it.y  = axis_in(reports.y_win);
    it.z1 = sample_t'($urandom_range(1, 4095));
    pw    = reports.press_win;
    target = (pw.lo <= pw.hi) ? $urandom_range(pw.lo, pw.hi) : $urandom_range(0, 4095);
    span   = longint'(it.x) * longint'(reports.plate);
    if (span == 0) begin
      it.z2 = sample_t'($urandom);
    end else begin
      z2_sum = it.z1 + (target * 4096 * it.z1) / span;
      it.z2  = (z2_sum > 4095) ? SAMPLE_MAX : sample_t'(z2_sum);
    end
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reports.write_reg(idx, data);
  endtask

  // Send one item after a gap chosen by the burst pattern; note it once accepted
  task automatic push_item(touch_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 6);
    end else begin
      burst_left--;
      gap = 0;
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= it.opcode;
    x_raw_i      <= it.x;
    y_raw_i      <= it.y;
    z1_raw_i     <= it.z1;
    z2_raw_i     <= it.z2;
    pen_lifted_i <= it.pen_lifted;
    do @(posedge clk_i); while (in_stall_o);
    reports.predict(it);
  endtask

  // Drop valid, wait out every expected result, then let a silent item finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_settings(int unsigned phase);
    case (phase % 4)
      0:       write_reg(CFG_PLATE, CFG_DW'(SAMPLE_MAX));
      1:       write_reg(CFG_PLATE, '0);
      2:       write_reg(CFG_PLATE, CFG_DW'(PLATE_RESET));
      default: write_reg(CFG_PLATE, CFG_DW'($urandom_range(1, 4095)));
    endcase
    write_reg(CFG_PRESS_WIN, pick_window());
    write_reg(CFG_X_WIN, pick_window());
    write_reg(CFG_Y_WIN, pick_window());
    write_reg(CFG_FLIP, CFG_DW'(phase % 4));
    case (phase)
      0:       write_reg(CFG_PENUP, '0);
      1:       write_reg(CFG_PENUP, CFG_DW'({TICK_W{1'b1}}));
      default: write_reg(CFG_PENUP, CFG_DW'($urandom_range(1, 5)));
    endcase
  endtask

  initial begin
    reports = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero inputs, plain touch, corners, oversized pressure
    push_item(make_sample(0, 100, 100, 200, 0));
    push_item(make_sample(100, 100, 0, 200, 0));
    push_item(make_sample(2048, 1000, 1000, 1200, 0));
    push_item(make_sample(4095, 4095, 4095, 4095, 0));
    push_item(make_sample(4095, 0, 1, 4095, 0));
    push_item(make_tick());
    push_item(make_sample(2048, 1000, 1000, 1200, 1));
    push_item(make_sample(0, 0, 0, 0, 1));
    push_item(make_tick());
    push_item(make_sample(1, 1, 2000, 1000, 0));
    drain();

    // Mirror X inside a narrow window; short countdown
    write_reg(CFG_PLATE, CFG_DW'(SAMPLE_MAX));
    write_reg(CFG_X_WIN, pack_window(100, 200));
    write_reg(CFG_FLIP, CFG_DW'(FLIP_X));
    write_reg(CFG_PENUP, CFG_DW'(2));
    push_item(make_sample(150, 7, 300, 300, 0));
    push_item(make_sample(4000, 7, 300, 300, 0));
    push_item(make_sample(50, 7, 300, 300, 0));
    push_item(make_sample(120, 4095, 300, 100, 0));
    push_item(make_tick());
    push_item(make_tick());
    drain();

    // Inverted Y window, both axes mirrored, countdown of zero
    write_reg(CFG_PENUP, '0);
    write_reg(CFG_FLIP, CFG_DW'(FLIP_X | FLIP_Y));
    write_reg(CFG_Y_WIN, pack_window(20, 10));
    push_item(make_sample(150, 15, 300, 300, 0));
    push_item(make_sample(150, 15, 300, 299, 1));
    push_item(make_sample(4095, 15, 4095, 1, 0));
    push_item(make_tick());
    drain();

    // Single-value pressure window; writes to undecoded indexes are ignored
    write_reg(CFG_PLATE, CFG_DW'(PLATE_RESET));
    write_reg(CFG_X_WIN, FULL_WINDOW);
    write_reg(CFG_Y_WIN, FULL_WINDOW);
    write_reg(CFG_FLIP, '0);
    write_reg(CFG_PRESS_WIN, pack_window(45, 45));
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    push_item(make_sample(2048, 1000, 1000, 1200, 0));
    push_item(make_sample(2048, 1000, 1000, 1210, 0));
    push_item(make_sample(2048, 1000, 1000, 1000, 0));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      random_settings(phase);
      repeat (ITEMS_PER_PHASE) push_item(random_item());
    end
    drain();

    if (reports.failures == 0 && reports.outstanding() == 0)
      $display("resistive_touch_sample_qualifier_unit regression: pass");
    else
      $display("resistive_touch_sample_qualifier_unit regression: fail");
    $finish;
  end
endmodule
